// File: src/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the affine ring pixel coverage block.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int COORD_BITS = 12;
  localparam int COEF_W     = 24;
  localparam int RAD_W      = 16;
  localparam int SETUP_W    = 9;
  localparam int THICK_W    = 8;
  localparam int FILL_BIT   = 8;
  localparam int FRAC_SHIFT = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam int PROD_W    = COEF_W + COORD_BITS;
  localparam int LX_W      = PROD_W + 2;
  localparam int DX_W      = LX_W - FRAC_SHIFT + 1;
  localparam int D2_W      = 2 * DX_W;
  localparam int RAD_EXT_W = RAD_W + 1;
  localparam int R2_W      = 2 * RAD_EXT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_XX     = 3'd0,
    REG_INV_XY     = 3'd1,
    REG_INV_TX     = 3'd2,
    REG_INV_YX     = 3'd3,
    REG_INV_YY     = 3'd4,
    REG_INV_TY     = 3'd5,
    REG_RADIUS     = 3'd6,
    REG_RING_SETUP = 3'd7
  } cfg_idx_e;

  localparam logic signed [COEF_W-1:0]  RST_INV_ONE  = 24'sd65536;
  localparam logic signed [COEF_W-1:0]  RST_INV_ZERO = 24'sd0;
  localparam logic signed [RAD_W-1:0]   RST_RADIUS   = 16'sd0;
  localparam logic [SETUP_W-1:0]        RST_SETUP    = 9'd1;

  typedef struct packed {
    logic signed [COEF_W-1:0]  inv_xx;
    logic signed [COEF_W-1:0]  inv_xy;
    logic signed [COEF_W-1:0]  inv_tx;
    logic signed [COEF_W-1:0]  inv_yx;
    logic signed [COEF_W-1:0]  inv_yy;
    logic signed [COEF_W-1:0]  inv_ty;
    logic signed [RAD_W-1:0]   circle_radius;
    logic [SETUP_W-1:0]        ring_setup;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         covered;
  } pix_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [DX_W-1:0]       dx;
    logic signed [DX_W-1:0]       dy;
    logic [R2_W-1:0]              ro2;
    logic [R2_W-1:0]              ri2;
    logic                         r_pos;
    logic                         ri_pos;
    logic                         filled;
  } dist_t;

endpackage

// File: src/arpc_cfg.sv
// ----------------------------------------------------------------------------
// arpc_cfg
// Configuration register file: transform, radius and ring setup.
// ----------------------------------------------------------------------------
module arpc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output arpc_pkg::cfg_t                      cfg_o
);
  import arpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_INV_XX:     cfg_d.inv_xx        = cfg_data_i[COEF_W-1:0];
        REG_INV_XY:     cfg_d.inv_xy        = cfg_data_i[COEF_W-1:0];
        REG_INV_TX:     cfg_d.inv_tx        = cfg_data_i[COEF_W-1:0];
        REG_INV_YX:     cfg_d.inv_yx        = cfg_data_i[COEF_W-1:0];
        REG_INV_YY:     cfg_d.inv_yy        = cfg_data_i[COEF_W-1:0];
        REG_INV_TY:     cfg_d.inv_ty        = cfg_data_i[COEF_W-1:0];
        REG_RADIUS:     cfg_d.circle_radius = cfg_data_i[RAD_W-1:0];
        REG_RING_SETUP: cfg_d.ring_setup    = cfg_data_i[SETUP_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_xx        <= RST_INV_ONE;
      cfg_q.inv_xy        <= RST_INV_ZERO;
      cfg_q.inv_tx        <= RST_INV_ZERO;
      cfg_q.inv_yx        <= RST_INV_ZERO;
      cfg_q.inv_yy        <= RST_INV_ONE;
      cfg_q.inv_ty        <= RST_INV_ZERO;
      cfg_q.circle_radius <= RST_RADIUS;
      cfg_q.ring_setup    <= RST_SETUP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: src/arpc_xform.sv
// ----------------------------------------------------------------------------
// arpc_xform
// Stages 1-2: affine products, then sum, floor to 1/16 pixel, radius offset.
// ----------------------------------------------------------------------------
module arpc_xform (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  arpc_pkg::pix_in_t pix_i,
  input  arpc_pkg::cfg_t    cfg_i,
  output logic              valid_o,
  output arpc_pkg::dist_t   dist_o
);
  import arpc_pkg::*;

  logic signed [PROD_W-1:0]     p_xx_d, p_xy_d, p_yx_d, p_yy_d;
  logic signed [PROD_W-1:0]     p_xx_q, p_xy_q, p_yx_q, p_yy_q;
  logic signed [RAD_EXT_W-1:0]  ro, ri, half_t;
  logic signed [R2_W-1:0]       ro_w, ri_w, ro2_s, ri2_s;
  logic [R2_W-1:0]              ro2_q, ri2_q;
  logic                         r_pos_q, ri_pos_q, filled_q;
  logic signed [COORD_BITS-1:0] x_q, y_q;
  logic                         s1_valid_q, s2_valid_q;
  logic signed [LX_W-1:0]       lx, ly;
  dist_t                        dist_d, dist_q;

  always_comb begin
    p_xx_d = cfg_i.inv_xx * pix_i.pixel_x;
    p_xy_d = cfg_i.inv_xy * pix_i.pixel_y;
    p_yx_d = cfg_i.inv_yx * pix_i.pixel_x;
    p_yy_d = cfg_i.inv_yy * pix_i.pixel_y;
    half_t = $signed(RAD_EXT_W'({cfg_i.ring_setup[THICK_W-1:0], 3'b000}));
    ro     = RAD_EXT_W'(cfg_i.circle_radius) + half_t;
    ri     = RAD_EXT_W'(cfg_i.circle_radius) - half_t;
    ro_w   = R2_W'(ro);
    ri_w   = R2_W'(ri);
    ro2_s  = ro_w * ro_w;
    ri2_s  = ri_w * ri_w;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_xx_q   <= p_xx_d;
      p_xy_q   <= p_xy_d;
      p_yx_q   <= p_yx_d;
      p_yy_q   <= p_yy_d;
      ro2_q    <= ro2_s;
      ri2_q    <= ri2_s;
      r_pos_q  <= cfg_i.circle_radius > 0;
      ri_pos_q <= ri > 0;
      filled_q <= cfg_i.ring_setup[FILL_BIT];
      x_q      <= pix_i.pixel_x;
      y_q      <= pix_i.pixel_y;
      dist_q   <= dist_d;
    end
  end

  // floor to 1/16 pixel is the arithmetic shift by FRAC_SHIFT
  always_comb begin
    lx            = p_xx_q + p_xy_q + cfg_i.inv_tx;
    ly            = p_yx_q + p_yy_q + cfg_i.inv_ty;
    dist_d.x      = x_q;
    dist_d.y      = y_q;
    dist_d.dx     = $signed(lx[LX_W-1:FRAC_SHIFT]) - cfg_i.circle_radius;
    dist_d.dy     = $signed(ly[LX_W-1:FRAC_SHIFT]) - cfg_i.circle_radius;
    dist_d.ro2    = ro2_q;
    dist_d.ri2    = ri2_q;
    dist_d.r_pos  = r_pos_q;
    dist_d.ri_pos = ri_pos_q;
    dist_d.filled = filled_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  assign valid_o = s2_valid_q;
  assign dist_o  = dist_q;

endmodule

// File: src/arpc_dist.sv
// ----------------------------------------------------------------------------
// arpc_dist
// Stages 3-4: squared distance, ring compare, output register.
// ----------------------------------------------------------------------------
module arpc_dist (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  arpc_pkg::dist_t    dist_i,
  output logic               valid_o,
  output arpc_pkg::pix_out_t out_o
);
  import arpc_pkg::*;

  logic signed [D2_W-1:0]       sq_x_d, sq_y_d, sq_x_q, sq_y_q;
  logic signed [COORD_BITS-1:0] x_q, y_q;
  logic [R2_W-1:0]              ro2_q, ri2_q;
  logic                         r_pos_q, ri_pos_q, filled_q;
  logic                         s3_valid_q, out_valid_q;
  logic [D2_W-1:0]              d2;
  logic                         in_outer, in_inner;
  pix_out_t                     out_d, out_q;

  always_comb begin
    sq_x_d = dist_i.dx * dist_i.dx;
    sq_y_d = dist_i.dy * dist_i.dy;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_x_q   <= sq_x_d;
      sq_y_q   <= sq_y_d;
      x_q      <= dist_i.x;
      y_q      <= dist_i.y;
      ro2_q    <= dist_i.ro2;
      ri2_q    <= dist_i.ri2;
      r_pos_q  <= dist_i.r_pos;
      ri_pos_q <= dist_i.ri_pos;
      filled_q <= dist_i.filled;
      out_q    <= out_d;
    end
  end

  always_comb begin
    d2            = unsigned'(sq_x_q) + unsigned'(sq_y_q);
    in_outer      = d2 <= D2_W'(ro2_q);
    in_inner      = filled_q || !ri_pos_q || (d2 >= D2_W'(ri2_q));
    out_d.out_x   = x_q;
    out_d.out_y   = y_q;
    out_d.covered = r_pos_q && in_outer && in_inner;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q  <= valid_i;
      out_valid_q <= s3_valid_q;
    end
  end

  assign valid_o = out_valid_q;
  assign out_o   = out_q;

endmodule

// File: src/affine_ring_pixel_coverage_top.sv
// ----------------------------------------------------------------------------
// affine_ring_pixel_coverage_top
// Tests screen pixels against a transformed disc or ring.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_stall_o/in_data_i) takes one pixel item per
//   cycle unless in_stall_o is high. Output channel (out_valid_o/out_stall_i/
//   out_data_o) returns the pixel with its covered flag, in input order, one
//   result per item. Config channel (cfg_valid_i/cfg_ready_o) writes register
//   cfg_idx_i with cfg_data_i; ready is always high. Write only while no
//   item is in flight. Each result passes through the four register stages
//   (products, affine sum, squares, compare/output).
//   Throughput: one item per cycle while the output is not stalled.
//   Stall: the pipeline advances as one; while a valid result is held by
//   out_stall_i, all stages freeze and in_stall_o is raised. Nothing is
//   lost or repeated.
//   Reset: all stages empty, registers return to identity transform,
//   radius zero and thickness one.
// ----------------------------------------------------------------------------
module affine_ring_pixel_coverage_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  arpc_pkg::pix_in_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output arpc_pkg::pix_out_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import arpc_pkg::*;

  cfg_t  cfg;
  dist_t xf_dist;
  logic  en, xf_valid;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  arpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  arpc_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pix_i   (in_data_i),
    .cfg_i   (cfg),
    .valid_o (xf_valid),
    .dist_o  (xf_dist)
  );

  arpc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (xf_valid),
    .dist_i  (xf_dist),
    .valid_o (out_valid_o),
    .out_o   (out_data_o)
  );

endmodule

// File: src/arpc_checker.sv
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level assertions for the pixel coverage block, bound to the top.
// ----------------------------------------------------------------------------
module arpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input arpc_pkg::pix_in_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input arpc_pkg::pix_out_t out_data_o
);
  import arpc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result item changed");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i)
    |=> out_valid_o && (out_data_o.out_x == $past(in_data_i.pixel_x, 4))
        && (out_data_o.out_y == $past(in_data_i.pixel_y, 4)))
    else $error("item not delivered after four cycles");

endmodule

bind affine_ring_pixel_coverage_top arpc_checker u_arpc_checker (.*);
